@@ hw/rtl/tge_pkg.sv @@
// Shared types, codes and helpers for the touch gesture event queue.
// No dependencies; imported by every module of the block.
package tge_pkg;

    // Default ring depth, reset tolerances and field widths
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int COORD_W         = 16;
    localparam int TOL_W           = 8;
    localparam int QUEUED_W        = 3;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = TOL_W;

    localparam logic [TOL_W-1:0] MOVE_TOL_RST  = 8'd2;
    localparam logic [TOL_W-1:0] CLICK_TOL_RST = 8'd8;

    // Gesture event codes
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_DOWN  = 3'd1,
        EV_MOVE  = 3'd2,
        EV_CLICK = 3'd3,
        EV_UP    = 3'd4
    } ev_t;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_POLL   = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOVE_TOL  = 1'd0,
        CFG_CLICK_TOL = 1'd1
    } cfg_idx_t;

    // Input request
    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] sample_x;
        logic signed [COORD_W-1:0] sample_y;
        logic                      sample_pressed;
    } item_t;

    // Result
    typedef struct packed {
        ev_t                       event_res;
        logic signed [COORD_W-1:0] current_x;
        logic signed [COORD_W-1:0] current_y;
        logic [QUEUED_W-1:0]       queued;
    } result_t;

    // Tolerance registers handed to the gesture logic
    typedef struct packed {
        logic [TOL_W-1:0] drag_lim;
        logic [TOL_W-1:0] tap_lim;
    } tol_t;

    // Push request from the gesture logic to the ring
    typedef struct packed {
        logic push;
        ev_t  ev;
    } push_req_t;

    // True when a signed offset lies beyond +/- tol
    function automatic logic outside_tol(input logic signed [COORD_W-1:0] d,
                                         input logic [TOL_W-1:0] tol);
        logic signed [COORD_W:0] de;
        logic signed [COORD_W:0] te;
        de = {d[COORD_W-1], d};
        te = {{(COORD_W+1-TOL_W){1'b0}}, tol};
        return (de > te) || (de < -te);
    endfunction

endpackage

@@ hw/rtl/touch_gesture_event_queue.sv @@
// Touch click/drag gesture detector with a small event ring.
//
// Input channel s_valid/s_ready/s_item: each request is a touch sample
// (kind 0: x, y, pressed) or a poll (kind 1). A press edge queues DOWN, a
// held sample beyond the move tolerance queues MOVE, a release queues CLICK
// when both offsets lie within the click tolerance and UP otherwise. A full
// ring drops its oldest event. A poll pops one event, or EV_NONE when empty.
// Output channel m_valid/m_ready/m_result: one result per request carrying
// the popped event, the latest coordinates and the number of queued events.
// An accepted request is held in the input register, which feeds the
// gesture compare and ring update; these load the result register when it
// is free or draining. Throughput is one request per cycle while m_ready
// stays high, as touch state and ring update as each request is processed.
// When m_ready is low the result register holds and the input register
// still takes one more request; s_ready drops only when both are full.
// Tolerance registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while idle, which the block does not enforce.
// Reset (aresetn low, synchronous) empties the ring, clears the touch state
// and loads tolerances 2 (move), 8 (click). Depends on tge_pkg, tge_gesture, tge_ring.
module touch_gesture_event_queue
    import tge_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  item_t                 s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tol_t                      tol_reg;
    logic                      in_valid_reg;
    item_t                     in_item_reg;
    logic                      out_valid_reg;
    result_t                   result_reg;

    logic                      advance;
    logic                      fire;
    push_req_t                 push_req;
    ev_t                       pop_ev;
    logic [CNT_W-1:0]          fill_next;
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg.drag_lim <= MOVE_TOL_RST;
            tol_reg.tap_lim  <= CLICK_TOL_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MOVE_TOL:  tol_reg.drag_lim <= cfg_data;
                CFG_CLICK_TOL: tol_reg.tap_lim  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: process when the result register is free or draining
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    tge_gesture u_gesture (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .item     (in_item_reg),
        .tol      (tol_reg),
        .push_req (push_req),
        .cur_x    (cur_x),
        .cur_y    (cur_y)
    );

    tge_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop       (fire && (in_item_reg.kind == KIND_POLL)),
        .push_req  (push_req),
        .pop_ev    (pop_ev),
        .fill_next (fill_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg.event_res <= pop_ev;
            result_reg.current_x <= cur_x;
            result_reg.current_y <= cur_y;
            result_reg.queued    <= QUEUED_W'(fill_next);
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = result_reg;

endmodule

@@ hw/rtl/tge_gesture.sv @@
// Touch state tracker: held flag, down point and latest coordinates.
// Decides which gesture event a sample raises. Depends on tge_pkg.
module tge_gesture
    import tge_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      fire,
    input  item_t                     item,
    input  tol_t                      tol,
    output push_req_t                 push_req,
    output logic signed [COORD_W-1:0] cur_x,
    output logic signed [COORD_W-1:0] cur_y
);

    logic                      held_reg;
    logic signed [COORD_W-1:0] last_x_reg;
    logic signed [COORD_W-1:0] last_y_reg;
    logic signed [COORD_W-1:0] down_x_reg;
    logic signed [COORD_W-1:0] down_y_reg;

    logic                      is_sample;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic                      moved;
    logic                      clicked;

    assign is_sample = (item.kind == KIND_SAMPLE);

    // Wrapping offsets from the down point
    assign dx      = item.sample_x - down_x_reg;
    assign dy      = item.sample_y - down_y_reg;
    assign moved   = outside_tol(dx, tol.drag_lim) || outside_tol(dy, tol.drag_lim);
    assign clicked = !outside_tol(dx, tol.tap_lim) && !outside_tol(dy, tol.tap_lim);

    // Pick the event for a sample
    always_comb begin
        push_req.push = 1'b0;
        push_req.ev   = EV_NONE;
        if (fire && is_sample) begin
            if (!held_reg && item.sample_pressed) begin
                push_req.push = 1'b1;
                push_req.ev   = EV_DOWN;
            end else if (held_reg && item.sample_pressed) begin
                push_req.push = moved;
                push_req.ev   = EV_MOVE;
            end else if (held_reg) begin
                push_req.push = 1'b1;
                push_req.ev   = clicked ? EV_CLICK : EV_UP;
            end
        end
    end

    // Coordinates as they stand after this request
    assign cur_x = is_sample ? item.sample_x : last_x_reg;
    assign cur_y = is_sample ? item.sample_y : last_y_reg;

    // Update touch state on samples
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg   <= 1'b0;
            last_x_reg <= '0;
            last_y_reg <= '0;
            down_x_reg <= '0;
            down_y_reg <= '0;
        end else if (fire && is_sample) begin
            held_reg   <= item.sample_pressed;
            last_x_reg <= item.sample_x;
            last_y_reg <= item.sample_y;
            if (!held_reg && item.sample_pressed) begin
                down_x_reg <= item.sample_x;
                down_y_reg <= item.sample_y;
            end
        end
    end

endmodule

@@ hw/rtl/tge_ring.sv @@
// Event ring: push drops the oldest entry when full, pop returns the oldest.
// Depends on tge_pkg.
module tge_ring
    import tge_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 pop,
    input  push_req_t                            push_req,
    output ev_t                                  pop_ev,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     fill_next
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ev_t              store [QUEUE_DEPTH];
    logic [PTR_W-1:0] read_pos_reg;
    logic [PTR_W-1:0] read_pos_next;
    logic [CNT_W-1:0] fill_count_reg;

    logic             full;
    logic             empty;
    logic [PTR_W-1:0] rp_inc;
    logic [PTR_W:0]   wr_sum;
    logic [PTR_W-1:0] wr_idx;

    assign full  = (fill_count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (fill_count_reg == '0);

    // Advance pointer with wrap at the depth
    assign rp_inc = (read_pos_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : read_pos_reg + 1'b1;

    // Tail slot; a full ring overwrites the oldest slot
    assign wr_sum = {1'b0, read_pos_reg} + (PTR_W+1)'(fill_count_reg);
    always_comb begin
        if (full) begin
            wr_idx = read_pos_reg;
        end else if (wr_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
            wr_idx = PTR_W'(wr_sum - (PTR_W+1)'(QUEUE_DEPTH));
        end else begin
            wr_idx = wr_sum[PTR_W-1:0];
        end
    end

    assign pop_ev = (pop && !empty) ? store[read_pos_reg] : EV_NONE;

    // Next pointer and fill
    always_comb begin
        read_pos_next = read_pos_reg;
        fill_next     = fill_count_reg;
        if (pop && !empty) begin
            read_pos_next = rp_inc;
            fill_next     = fill_count_reg - 1'b1;
        end else if (push_req.push) begin
            if (full) begin
                read_pos_next = rp_inc;
            end else begin
                fill_next = fill_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_pos_reg   <= '0;
            fill_count_reg <= '0;
        end else begin
            read_pos_reg   <= read_pos_next;
            fill_count_reg <= fill_next;
        end
    end

    // Store write
    always_ff @(posedge aclk) begin
        if (push_req.push) begin
            store[wr_idx] <= push_req.ev;
        end
    end

    ap_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("ring fill above depth");

    ap_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        read_pos_reg <= PTR_W'(QUEUE_DEPTH - 1))
        else $error("ring read pointer out of range");

    ap_push_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        push_req.push |=> !empty)
        else $error("ring empty after push");

    ap_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && empty) |=> ($stable(read_pos_reg) && empty))
        else $error("pop on empty ring changed state");

    ap_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && push_req.push))
        else $error("push and pop in the same cycle");

endmodule
